/* rtl/core/swt_pkg.sv */
// shared types and codes for the sleep/wakeup timer table
`timescale 1ns / 1ps

package swt_pkg;

    // opcodes of an input beat
    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_SLEEP  = 2'd1;
    localparam logic [1:0] OP_CANCEL = 2'd2;

    // event kinds of a result beat
    localparam logic [2:0] EV_EXPIRED = 3'd0;
    localparam logic [2:0] EV_CANCEL  = 3'd1;
    localparam logic [2:0] EV_ACCEPT  = 3'd2;
    localparam logic [2:0] EV_FULL    = 3'd3;
    localparam logic [2:0] EV_ABSENT  = 3'd4;

    localparam logic [15:0] TPS_RESET = 16'd18;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [7:0]  pid;
        logic [15:0] seconds;
    } t_in_beat;

    typedef struct packed {
        logic [2:0] event_kind;
        logic [7:0] woken_pid;
        logic       last;
    } t_out_beat;

    // one table entry as stored in the slot memory
    typedef struct packed {
        logic [7:0]  pid;
        logic [31:0] start;
        logic [31:0] dur;
    } t_slot;

    // result handed from the scan engine to the output register
    typedef struct packed {
        logic      vld;
        t_out_beat data;
    } t_push;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FLUSH
    } t_state;

endpackage

/* rtl/core/sleep_wakeup_timer_table_core.sv */
// top level: config register, scan engine, slot memory and output register
`timescale 1ns / 1ps
//
// Sleep/wakeup timer table. Input beats carry an opcode (tick, sleep request,
// cancel by pid), a pid and a sleep length in seconds; output beats carry an
// event kind, the pid concerned and a last flag on the final beat of an item.
// Both channels use valid/stall; the config channel (valid/ready, always
// ready) writes ticks_per_second, which is to be written only while the block
// is idle; the block itself does not enforce this. One item is worked at a
// time. A tick or cancel sweeps the slot memory one slot per cycle through its
// registered read port, pausing while a wake waits on a stalled output register;
// a sleep request walks the valid bits to the lowest free slot, then a flush step.
// A tick may give zero to SLOTS beats; sleep and cancel always give one.
// When the receiver stalls, the output register holds its beat; the sweep
// pauses only when it has a further beat to push, until that is taken. The next
// input is accepted once the last beat of the item sits in the output register.
// Reset clears the tick counter and all valid bits and sets ticks_per_second
// to 18; the slot memory needs no clearing pass.
//

module sleep_wakeup_timer_table_core
    import swt_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  t_in_beat    i_in_data,
    output logic        o_in_stall,
    output logic        o_out_valid,
    output t_out_beat   o_out_data,
    input  logic        i_out_stall,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    localparam int IW = $clog2(SLOTS);

    logic [15:0]   r_tps;
    logic          r_out_valid;
    t_out_beat     r_out_data;
    t_push         push;
    logic          push_rdy;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    t_slot         wr_data;
    logic          rd_en;
    logic [IW-1:0] rd_addr;
    t_slot         rd_data;

    // config register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tps <= TPS_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_tps <= i_cfg_data;
        end
    end

    swt_scan #(
        .SLOTS (SLOTS),
        .IW    (IW)
    ) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .i_tps      (r_tps),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_data  (wr_data),
        .o_rd_en    (rd_en),
        .o_rd_addr  (rd_addr),
        .i_rd_data  (rd_data),
        .o_push     (push),
        .i_push_rdy (push_rdy)
    );

    swt_slot_mem #(
        .SLOTS (SLOTS),
        .IW    (IW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // output register: takes a new beat when empty or being drained
    assign push_rdy = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (push.vld && push_rdy) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push.vld && push_rdy) begin
            r_out_data <= push.data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

/* rtl/core/swt_slot_mem.sv */
// slot memory: pid, start tick and duration per slot, one write and one read port
`timescale 1ns / 1ps

module swt_slot_mem
    import swt_pkg::*;
#(
    parameter int SLOTS = 16,
    parameter int IW    = $clog2(SLOTS)
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [IW-1:0] i_wr_addr,
    input  t_slot         i_wr_data,
    input  logic          i_rd_en,
    input  logic [IW-1:0] i_rd_addr,
    output t_slot         o_rd_data
);

    t_slot r_mem [SLOTS];
    t_slot r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port, holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/core/swt_scan.sv */
// scan engine: tick counter, valid bits and per-slot sweep for tick, sleep and cancel
`timescale 1ns / 1ps

module swt_scan
    import swt_pkg::*;
#(
    parameter int SLOTS = 16,
    parameter int IW    = $clog2(SLOTS)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  t_in_beat      i_in_data,
    output logic          o_in_stall,
    input  logic [15:0]   i_tps,
    output logic          o_wr_en,
    output logic [IW-1:0] o_wr_addr,
    output t_slot         o_wr_data,
    output logic          o_rd_en,
    output logic [IW-1:0] o_rd_addr,
    input  t_slot         i_rd_data,
    output t_push         o_push,
    input  logic          i_push_rdy
);

    localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

    t_state           r_state, n_state;
    logic [1:0]       r_op, n_op;
    logic [7:0]       r_pid, n_pid;
    logic [31:0]      r_dur, n_dur;
    logic [31:0]      r_tick, n_tick;
    logic [SLOTS-1:0] r_valid, n_valid;
    logic [IW-1:0]    r_addr, n_addr;
    logic             r_issue, n_issue;
    logic             r_ev_vld, n_ev_vld;
    logic [IW-1:0]    r_eidx, n_eidx;
    logic             r_pend_vld, n_pend_vld;
    logic [2:0]       r_pend_kind, n_pend_kind;
    logic [7:0]       r_pend_pid, n_pend_pid;

    logic        hit;
    logic        go;
    logic        end_scan;
    logic [31:0] elapsed;

    // elapsed ticks of the entry coming out of memory
    assign elapsed  = r_tick - i_rd_data.start;
    assign end_scan = r_ev_vld && (r_eidx == LAST_IDX);

    always_comb begin
        if (r_op == OP_TICK) begin
            hit = r_ev_vld && r_valid[r_eidx] && (elapsed >= i_rd_data.dur);
        end else begin
            hit = r_ev_vld && r_valid[r_eidx] && (i_rd_data.pid == r_pid);
        end
    end

    // next state and outputs
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_pid       = r_pid;
        n_dur       = r_dur;
        n_tick      = r_tick;
        n_valid     = r_valid;
        n_addr      = r_addr;
        n_issue     = r_issue;
        n_ev_vld    = r_ev_vld;
        n_eidx      = r_eidx;
        n_pend_vld  = r_pend_vld;
        n_pend_kind = r_pend_kind;
        n_pend_pid  = r_pend_pid;
        o_push      = '0;
        o_rd_en     = 1'b0;
        o_rd_addr   = r_addr;
        o_wr_en     = 1'b0;
        o_wr_addr   = r_addr;
        o_wr_data   = '{pid: r_pid, start: r_tick, dur: r_dur};
        go          = 1'b1;
        o_in_stall  = (r_state != S_IDLE);

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op       = i_in_data.opcode;
                    n_pid      = i_in_data.pid;
                    n_dur      = {16'd0, i_in_data.seconds} * {16'd0, i_tps};
                    n_addr     = '0;
                    n_issue    = 1'b1;
                    n_ev_vld   = 1'b0;
                    n_pend_vld = 1'b0;
                    case (i_in_data.opcode) inside
                        OP_TICK: begin
                            n_tick  = r_tick + 32'd1;
                            n_state = S_SCAN;
                        end
                        OP_SLEEP, OP_CANCEL: begin
                            n_state = S_SCAN;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (r_op == OP_SLEEP) begin
                    // lowest free slot takes the new entry
                    if (!r_valid[r_addr]) begin
                        o_wr_en           = 1'b1;
                        n_valid[r_addr]   = 1'b1;
                        n_pend_vld        = 1'b1;
                        n_pend_kind       = EV_ACCEPT;
                        n_pend_pid        = r_pid;
                        n_state           = S_FLUSH;
                    end else if (r_addr == LAST_IDX) begin
                        n_pend_vld  = 1'b1;
                        n_pend_kind = EV_FULL;
                        n_pend_pid  = r_pid;
                        n_state     = S_FLUSH;
                    end else begin
                        n_addr = r_addr + 1'b1;
                    end
                end else begin
                    // a new wake sends the held one out, not marked last
                    if ((r_op == OP_TICK) && hit && r_pend_vld) begin
                        o_push.vld             = 1'b1;
                        o_push.data.event_kind = r_pend_kind;
                        o_push.data.woken_pid  = r_pend_pid;
                        o_push.data.last       = 1'b0;
                        go                     = i_push_rdy;
                    end
                    if (go) begin
                        // read pipeline: issue next address, evaluate previous
                        if (r_issue) begin
                            o_rd_en  = 1'b1;
                            n_addr   = r_addr + 1'b1;
                            n_issue  = (r_addr != LAST_IDX);
                            n_ev_vld = 1'b1;
                            n_eidx   = r_addr;
                        end else begin
                            n_ev_vld = 1'b0;
                        end
                        if (hit) begin
                            n_valid[r_eidx] = 1'b0;
                            n_pend_vld      = 1'b1;
                            n_pend_kind     = (r_op == OP_TICK) ? EV_EXPIRED : EV_CANCEL;
                            n_pend_pid      = i_rd_data.pid;
                        end
                        if ((r_op != OP_TICK) && hit) begin
                            n_state = S_FLUSH;
                        end else if (end_scan) begin
                            if (r_op == OP_TICK) begin
                                n_state = (hit || r_pend_vld) ? S_FLUSH : S_IDLE;
                            end else begin
                                n_pend_vld  = 1'b1;
                                n_pend_kind = EV_ABSENT;
                                n_pend_pid  = r_pid;
                                n_state     = S_FLUSH;
                            end
                        end
                    end
                end
            end
            S_FLUSH: begin
                // final beat of the item
                o_push.vld             = 1'b1;
                o_push.data.event_kind = r_pend_kind;
                o_push.data.woken_pid  = r_pend_pid;
                o_push.data.last       = 1'b1;
                if (i_push_rdy) begin
                    n_pend_vld = 1'b0;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick     <= '0;
            r_valid    <= '0;
            r_issue    <= 1'b0;
            r_ev_vld   <= 1'b0;
            r_pend_vld <= 1'b0;
            r_op       <= OP_TICK;
        end else begin
            r_tick     <= n_tick;
            r_valid    <= n_valid;
            r_issue    <= n_issue;
            r_ev_vld   <= n_ev_vld;
            r_pend_vld <= n_pend_vld;
            r_op       <= n_op;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_pid       <= n_pid;
        r_dur       <= n_dur;
        r_addr      <= n_addr;
        r_eidx      <= n_eidx;
        r_pend_kind <= n_pend_kind;
        r_pend_pid  <= n_pend_pid;
    end

`ifndef ASSERT_OFF
    // a beat marked last only comes out of the flush step
    ap_last_in_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.vld && o_push.data.last) |-> (r_state == S_FLUSH))
        else $error("last beat pushed outside flush");

    // nothing is pushed while idle
    ap_no_push_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.vld |-> (r_state != S_IDLE))
        else $error("result pushed while idle");

    // the slot memory is written only by a sleep request during its sweep
    ap_wr_sleep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr_en |-> ((r_state == S_SCAN) && (r_op == OP_SLEEP) && !r_valid[o_wr_addr]))
        else $error("slot memory written outside a sleep sweep");

    // an accepted tick advances the counter by one
    ap_tick_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_IDLE) && i_in_valid && (i_in_data.opcode == OP_TICK))
        |=> (r_tick == $past(r_tick) + 32'd1))
        else $error("tick counter did not advance");

    // flush always has a held result to send
    ap_flush_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FLUSH) |-> r_pend_vld)
        else $error("flush without held result");
`endif

endmodule
